>>> hdl/foc_pkg.sv
package foc_pkg;

   localparam int IN_WIDTH   = 16;
   localparam int VOLT_WIDTH = 15;
   localparam int GAIN_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CUR_FRAC   = 12;
   localparam int TRIG_FRAC  = 14;
   localparam int INV_SQRT3_Q16 = 37837;
   localparam int INT_LIMIT  = 800 * 4096;
   localparam int VOLT_LIMIT = 2 * 4096;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      REG_PROP_GAIN_D = 2'd0,
      REG_INT_GAIN_D  = 2'd1,
      REG_PROP_GAIN_Q = 2'd2,
      REG_INT_GAIN_Q  = 2'd3
   } reg_index_type;

   // Datapath micro-operations, one per controller step
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_BETA,
      OP_MD0,
      OP_MD1,
      OP_MQ0,
      OP_MQ1,
      OP_ERR,
      OP_INTEG,
      OP_PD_KP,
      OP_PD_KI,
      OP_PQ_KP,
      OP_PQ_KI,
      OP_VA0,
      OP_VA1,
      OP_VB0
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sel_q;
      logic   last;
   } cmd_type;

endpackage

>>> hdl/foc_if.sv
interface foc_req_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] phase_a_current;
   logic signed [15:0] phase_b_current;
   logic signed [15:0] angle_sine;
   logic signed [15:0] angle_cosine;
   logic signed [15:0] target_d;
   logic signed [15:0] target_q;
   modport source (output valid, phase_a_current, phase_b_current, angle_sine,
                   angle_cosine, target_d, target_q, input ready);
   modport sink (input valid, phase_a_current, phase_b_current, angle_sine,
                 angle_cosine, target_d, target_q, output ready);
endinterface

interface foc_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] measured_d;
   logic signed [15:0] measured_q;
   logic signed [14:0] volt_d;
   logic signed [14:0] volt_q;
   logic signed [15:0] volt_alpha;
   logic signed [15:0] volt_beta;
   modport source (output valid, measured_d, measured_q, volt_d, volt_q,
                   volt_alpha, volt_beta, input ready);
   modport sink (input valid, measured_d, measured_q, volt_d, volt_q,
                 volt_alpha, volt_beta, output ready);
endinterface

>>> hdl/foc_current_loop.sv
// Channel | Dir | Payload
// req     | in  | phase_a/b_current, angle_sine/cosine, target_d/q
// rsp     | out | measured_d/q, volt_d/q, volt_alpha/beta
// csr     | in  | 2-bit index, 16-bit gain write
// An item is taken only in the idle state, so the next item is accepted only after the
// previous result is loaded into the output register: every product goes through a single
// shared multiplier with a registered accumulator, one term per cycle.
// Reset is synchronous and restores gains and zeroes both integrators.
// A result waits in an output register; if the previous result is still there, the
// block holds in its last step, and the next item is taken once the result is loaded.
module foc_current_loop #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int ACCUM_WIDTH  = 24
) (
   input  logic        clock,
   input  logic        reset,
   foc_req_if.sink     req,
   foc_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   foc_pkg::cmd_type cmd;

   foc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .cmd       (cmd)
   );

   foc_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ACCUM_WIDTH  (ACCUM_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_a             (req.phase_a_current),
      .in_b             (req.phase_b_current),
      .in_sin           (req.angle_sine),
      .in_cos           (req.angle_cosine),
      .in_td            (req.target_d),
      .in_tq            (req.target_q),
      .out_md           (rsp.measured_d),
      .out_mq           (rsp.measured_q),
      .out_vd           (rsp.volt_d),
      .out_vq           (rsp.volt_q),
      .out_va           (rsp.volt_alpha),
      .out_vb           (rsp.volt_beta)
   );

endmodule

>>> hdl/foc_ctrl.sv
module foc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output foc_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_BETA, S_MD0, S_MD1, S_MQ0, S_MQ1, S_ERRD, S_ERRQ, S_INTD, S_INTQ,
      S_PDKP, S_PDKI, S_PQKP, S_PQKI, S_VA0, S_VA1, S_VB0, S_VB1, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      cmd          = '{op: foc_pkg::OP_NONE, sel_q: 1'b0, last: 1'b0};
      in_ready     = 1'b0;
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.op   = foc_pkg::OP_LOAD;
               state_in = S_BETA;
            end
         end
         S_BETA: begin cmd.op = foc_pkg::OP_BETA; state_in = S_MD0; end
         S_MD0:  begin cmd.op = foc_pkg::OP_MD0;  state_in = S_MD1; end
         S_MD1:  begin cmd.op = foc_pkg::OP_MD1;  state_in = S_MQ0; end
         S_MQ0:  begin cmd.op = foc_pkg::OP_MQ0;  state_in = S_MQ1; end
         S_MQ1:  begin cmd.op = foc_pkg::OP_MQ1;  state_in = S_ERRD; end
         S_ERRD: begin cmd.op = foc_pkg::OP_ERR;  state_in = S_ERRQ; end
         S_ERRQ: begin cmd.op = foc_pkg::OP_ERR; cmd.sel_q = 1'b1; state_in = S_INTD; end
         S_INTD: begin cmd.op = foc_pkg::OP_INTEG; state_in = S_INTQ; end
         S_INTQ: begin cmd.op = foc_pkg::OP_INTEG; cmd.sel_q = 1'b1; state_in = S_PDKP; end
         S_PDKP: begin cmd.op = foc_pkg::OP_PD_KP; state_in = S_PDKI; end
         S_PDKI: begin cmd.op = foc_pkg::OP_PD_KI; state_in = S_PQKP; end
         S_PQKP: begin cmd.op = foc_pkg::OP_PQ_KP; state_in = S_PQKI; end
         S_PQKI: begin cmd.op = foc_pkg::OP_PQ_KI; state_in = S_VA0; end
         S_VA0:  begin cmd.op = foc_pkg::OP_VA0;  state_in = S_VA1; end
         S_VA1:  begin cmd.op = foc_pkg::OP_VA1;  state_in = S_VB0; end
         S_VB0:  begin cmd.op = foc_pkg::OP_VB0;  state_in = S_VB1; end
         S_VB1:  begin cmd.op = foc_pkg::OP_VA1; cmd.sel_q = 1'b1; state_in = S_OUT; end
         S_OUT: begin
            // wait for the previous item to drain from the output register
            if (!out_valid_ff || out_ready) begin
               cmd.last     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;

endmodule

>>> hdl/foc_dp.sv
module foc_dp #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int ACCUM_WIDTH  = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  foc_pkg::cmd_type        cmd,
   input  logic                    csr_write_enable,
   input  logic [foc_pkg::CSR_ADDR_WIDTH-1:0] csr_index,
   input  logic [foc_pkg::GAIN_WIDTH-1:0]     csr_write_data,
   input  logic signed [15:0]      in_a,
   input  logic signed [15:0]      in_b,
   input  logic signed [15:0]      in_sin,
   input  logic signed [15:0]      in_cos,
   input  logic signed [15:0]      in_td,
   input  logic signed [15:0]      in_tq,
   output logic signed [15:0]      out_md,
   output logic signed [15:0]      out_mq,
   output logic signed [14:0]      out_vd,
   output logic signed [14:0]      out_vq,
   output logic signed [15:0]      out_va,
   output logic signed [15:0]      out_vb
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int AW = ACCUM_WIDTH;
   // product width: one shared signed multiplier, operands of MA and 18 bits
   localparam int MA = (AW > SW + 2) ? AW : SW + 2;
   localparam int PW = MA + 18;
   // room for the Kp term moved up by 8 bits plus the Ki term
   localparam int SUMW = PW + 8;
   // integrator sum holds the +/-800 limit as well as any state plus error
   localparam int XW = (AW > SW) ? AW : SW;
   localparam int IW = (XW > 22) ? XW + 2 : 24;
   localparam logic signed [SUMW-1:0] SW_HI = SUMW'((64'sd1 <<< (SW - 1)) - 1);
   localparam logic signed [SUMW-1:0] SW_LO = -SW_HI - SUMW'(1);

   logic [15:0] kpd_ff, kid_ff, kpq_ff, kiq_ff;
   logic signed [15:0] a_ff, b_ff, sn_ff, cs_ff, td_ff, tq_ff;
   logic signed [SW-1:0] beta_ff, md_ff, mq_ff, ed_ff, eq_ff, va_ff, vb_ff;
   logic signed [14:0] ud_ff, uq_ff;
   logic signed [AW-1:0] intd_ff, intq_ff;
   logic signed [SUMW-1:0] acc_ff;
   logic signed [15:0] omd_ff, omq_ff, ova_ff, ovb_ff;
   logic signed [14:0] ovd_ff, ovq_ff;
   logic               vb_pend_ff;

   logic signed [MA-1:0] mul_x;
   logic signed [17:0]   mul_y;
   logic signed [PW-1:0] prod;
   logic signed [SUMW-1:0] acc_sum;
   logic signed [SUMW-1:0] r14, r16;
   logic signed [SW-1:0] sat14, sat16, err_sat;
   logic signed [SW+1:0] err_raw;
   logic signed [IW-1:0] integ_raw;
   logic signed [AW-1:0] integ_sat;
   logic signed [14:0]   volt_sat;
   logic signed [SUMW-1:0] acc_in;
   logic                 acc_add, acc_neg;

   function automatic logic signed [SW-1:0] sat_sw(input logic signed [SUMW-1:0] x);
      if (x > SW_HI) return SW_HI[SW-1:0];
      if (x < SW_LO) return SW_LO[SW-1:0];
      return x[SW-1:0];
   endfunction

   function automatic logic signed [15:0] sat16f(input logic signed [SW-1:0] x);
      logic signed [SW+1:0] e;
      e = (SW+2)'(x);
      if (e > (SW+2)'(32767)) return 16'sh7fff;
      if (e < -(SW+2)'(32768)) return 16'sh8000;
      return e[15:0];
   endfunction

   // multiplier operand select
   always_comb begin
      mul_x   = '0;
      mul_y   = '0;
      acc_add = 1'b0;
      acc_neg = 1'b0;
      case (cmd.op)
         foc_pkg::OP_BETA: begin
            mul_x = MA'(a_ff) + (MA'(b_ff) <<< 1);
            mul_y = 18'(foc_pkg::INV_SQRT3_Q16);
         end
         foc_pkg::OP_MD0: begin mul_x = MA'(a_ff); mul_y = 18'(cs_ff); end
         foc_pkg::OP_MD1: begin mul_x = MA'(beta_ff); mul_y = 18'(sn_ff); acc_add = 1'b1; end
         foc_pkg::OP_MQ0: begin mul_x = MA'(beta_ff); mul_y = 18'(cs_ff); end
         foc_pkg::OP_MQ1: begin
            mul_x = MA'(a_ff); mul_y = 18'(sn_ff); acc_add = 1'b1; acc_neg = 1'b1;
         end
         foc_pkg::OP_PD_KP: begin mul_x = MA'(ed_ff); mul_y = 18'(kpd_ff); end
         foc_pkg::OP_PD_KI: begin mul_x = MA'(intd_ff); mul_y = 18'(kid_ff); acc_add = 1'b1; end
         foc_pkg::OP_PQ_KP: begin mul_x = MA'(eq_ff); mul_y = 18'(kpq_ff); end
         foc_pkg::OP_PQ_KI: begin mul_x = MA'(intq_ff); mul_y = 18'(kiq_ff); acc_add = 1'b1; end
         foc_pkg::OP_VA0: begin mul_x = MA'(ud_ff); mul_y = 18'(cs_ff); end
         foc_pkg::OP_VA1: begin
            if (cmd.sel_q) begin
               mul_x = MA'(uq_ff); mul_y = 18'(cs_ff); acc_add = 1'b1;
            end else begin
               mul_x = MA'(uq_ff); mul_y = 18'(sn_ff); acc_add = 1'b1; acc_neg = 1'b1;
            end
         end
         foc_pkg::OP_VB0: begin mul_x = MA'(ud_ff); mul_y = 18'(sn_ff); end
         default: ;
      endcase
   end

   assign prod = PW'(mul_x) * PW'(mul_y);
   // Kp terms are scaled by 256 to line up with Ki terms
   always_comb begin
      acc_in = SUMW'(prod);
      if (cmd.op == foc_pkg::OP_PD_KP || cmd.op == foc_pkg::OP_PQ_KP) begin
         acc_in = SUMW'(prod) <<< 8;
      end
      if (acc_neg) acc_in = -acc_in;
      acc_sum = acc_add ? acc_ff + acc_in : acc_in;
   end

   // rounding of the accumulator (half up, floor shift)
   assign r14   = (acc_ff + SUMW'(1 << (foc_pkg::TRIG_FRAC - 1))) >>> foc_pkg::TRIG_FRAC;
   assign r16   = (acc_ff + SUMW'(1 << 15)) >>> 16;
   assign sat14 = sat_sw(r14);
   assign sat16 = sat_sw(r16);

   assign err_raw  = cmd.sel_q ? (SW+2)'(tq_ff) - (SW+2)'(mq_ff)
                               : (SW+2)'(td_ff) - (SW+2)'(md_ff);
   assign err_sat  = sat_sw(SUMW'(err_raw));

   always_comb begin
      integ_raw = cmd.sel_q ? IW'(intq_ff) + IW'(eq_ff)
                            : IW'(intd_ff) + IW'(ed_ff);
      if (integ_raw > IW'(foc_pkg::INT_LIMIT)) integ_raw = IW'(foc_pkg::INT_LIMIT);
      if (integ_raw < -IW'(foc_pkg::INT_LIMIT)) integ_raw = -IW'(foc_pkg::INT_LIMIT);
      if (integ_raw > IW'((64'sd1 <<< (AW - 1)) - 1)) begin
         integ_sat = {1'b0, {(AW-1){1'b1}}};
      end else if (integ_raw < -IW'(64'sd1 <<< (AW - 1))) begin
         integ_sat = {1'b1, {(AW-1){1'b0}}};
      end else begin
         integ_sat = integ_raw[AW-1:0];
      end
   end

   always_comb begin
      if (r16 > SUMW'(foc_pkg::VOLT_LIMIT)) volt_sat = 15'(foc_pkg::VOLT_LIMIT);
      else if (r16 < -SUMW'(foc_pkg::VOLT_LIMIT)) volt_sat = -15'(foc_pkg::VOLT_LIMIT);
      else volt_sat = r16[14:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kpd_ff  <= 16'd256;
         kid_ff  <= '0;
         kpq_ff  <= 16'd256;
         kiq_ff  <= '0;
         intd_ff <= '0;
         intq_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (foc_pkg::reg_index_type'(csr_index))
               foc_pkg::REG_PROP_GAIN_D: kpd_ff <= csr_write_data;
               foc_pkg::REG_INT_GAIN_D:  kid_ff <= csr_write_data;
               foc_pkg::REG_PROP_GAIN_Q: kpq_ff <= csr_write_data;
               foc_pkg::REG_INT_GAIN_Q:  kiq_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.op == foc_pkg::OP_INTEG) begin
            if (cmd.sel_q) intq_ff <= integ_sat;
            else           intd_ff <= integ_sat;
         end
      end
   end

   // many steps also consume the previous step's accumulator
   always_ff @(posedge clock) begin
      acc_ff <= acc_sum;
      case (cmd.op)
         foc_pkg::OP_LOAD: begin
            a_ff <= in_a; b_ff <= in_b; sn_ff <= in_sin; cs_ff <= in_cos;
            td_ff <= in_td; tq_ff <= in_tq;
         end
         foc_pkg::OP_MD0:  beta_ff <= sat16;
         foc_pkg::OP_MQ0:  md_ff   <= sat14;
         foc_pkg::OP_ERR: begin
            if (cmd.sel_q) eq_ff <= err_sat;
            else           ed_ff <= err_sat;
         end
         foc_pkg::OP_PQ_KP: ud_ff <= volt_sat;
         foc_pkg::OP_VA0:   uq_ff <= volt_sat;
         foc_pkg::OP_VB0:   va_ff <= sat14;
         default: ;
      endcase
      if (cmd.op == foc_pkg::OP_ERR && !cmd.sel_q) begin
         // accumulator still holds the q-current sum after its second step
         mq_ff <= sat14;
      end
      // beta-voltage sum sits in the accumulator only in the first output-wait cycle
      if (vb_pend_ff) begin
         vb_ff <= sat14;
      end
      if (cmd.last) begin
         omd_ff <= sat16f(md_ff);
         omq_ff <= sat16f(mq_ff);
         ovd_ff <= ud_ff;
         ovq_ff <= uq_ff;
         ova_ff <= sat16f(va_ff);
         ovb_ff <= sat16f(vb_pend_ff ? sat14 : vb_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vb_pend_ff <= 1'b0;
      else vb_pend_ff <= (cmd.op == foc_pkg::OP_VA1 && cmd.sel_q);
   end

   assign out_md = omd_ff;
   assign out_mq = omq_ff;
   assign out_vd = ovd_ff;
   assign out_vq = ovq_ff;
   assign out_va = ova_ff;
   assign out_vb = ovb_ff;

endmodule
